FILE: hdl/mbgs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbgs_pkg
// Shared constants and codes of the masked bilinear grid sampler.
// ----------------------------------------------------------------------------
package mbgs_pkg;

   // default grid store depth and index mode
   localparam int GRID_ENTRIES_DEFAULT = 65536;
   localparam int WRAP_INDICES_DEFAULT = 0;

   // request kinds
   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   // configuration register indexes
   typedef enum logic [2:0] {
      REG_LAT_FIRST = 3'd0,
      REG_LON_FIRST = 3'd1,
      REG_LAT_STEP  = 3'd2,
      REG_LON_STEP  = 3'd3,
      REG_ROWS      = 3'd4,
      REG_COLS      = 3'd5,
      REG_CLAMP_MIN = 3'd6,
      REG_CLAMP_MAX = 3'd7
   } cfg_reg_type;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   // grid node word: {net_valid, data_valid, value}
   localparam int NODE_W = 34;

   // column remainder pipeline: dividend bits and steps per stage
   localparam int MOD_DIVIDEND_W = 32;
   localparam int MOD_STEPS      = 4;
   localparam int MOD_STAGES     = MOD_DIVIDEND_W / MOD_STEPS;

   // request and response payload widths
   localparam int REQ_DATA_W = 120;
   localparam int RSP_DATA_W = 32;

endpackage
`default_nettype wire

FILE: hdl/masked_bilinear_grid_sampler_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// masked_bilinear_grid_sampler_top
// Stores a masked row-major grid and answers bilinear sample queries.
//
//  channel  dir  handshake             payload
//  req      in   req_tvalid/tready     tuser: kind; tdata: node and query
//  rsp      out  rsp_tvalid/tready     tuser: sample_ok; tdata: sampled_value
//  csr      in   csr_we                csr_index, csr_wdata
//
// One request per cycle while the pipeline does not stall; a query's response
// passes the 8-stage column remainder pipeline, the four corner RAM reads and
// the output register. Writes give no response. Synchronous reset clears
// control and loads register defaults; grid contents are undefined until
// written. Each stage stalls only when the stage ahead is full and stalled,
// so bubbles close up.
// ----------------------------------------------------------------------------
module masked_bilinear_grid_sampler_top #(
   parameter int GRID_ENTRIES = mbgs_pkg::GRID_ENTRIES_DEFAULT,
   parameter int WRAP_INDICES = mbgs_pkg::WRAP_INDICES_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // [15:0] node_index, [47:16] node_value, [48] data_valid, [49] net_valid,
   // [81:50] query_lat, [113:82] query_lon, [119:114] zero
   input  wire logic [mbgs_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [0] kind
   input  wire logic                              req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // [31:0] sampled_value
   output logic      [mbgs_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // [0] sample_ok
   output logic                                   rsp_tuser,
   input  wire logic                              csr_we,
   input  wire logic [mbgs_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [mbgs_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int AW      = $clog2(GRID_ENTRIES);
   localparam int S_MOD0  = 3;
   localparam int S_ADDR  = S_MOD0 + mbgs_pkg::MOD_STAGES;
   localparam int S_MEM   = S_ADDR + 1;
   localparam int S_ROW   = S_MEM + 1;
   localparam int S_COL   = S_ROW + 1;
   localparam int NS      = S_COL + 1;

   typedef struct packed {
      logic               kind;
      logic               wr_ok;
      logic [AW-1:0]      wr_addr;
      logic [31:0]        wr_value;
      logic               wr_dv;
      logic               wr_nv;
      logic signed [32:0] d_lat;
      logic signed [32:0] d_lon;
      logic signed [63:0] sl;
      logic signed [63:0] sn;
      logic               fail;
      logic [10:0]        i_w;
      logic [15:0]        fx;
      logic signed [16:0] fy;
      logic               j_neg;
      logic [30:0]        j_abs;
      logic [10:0]        rem;
      logic [31:0]        div_sh;
      logic [AW-1:0]      a00;
      logic signed [34:0] r0;
      logic signed [34:0] r1;
      logic               corners_ok;
      logic signed [36:0] v;
   } item_type;

   // configuration registers
   logic signed [31:0] lat_first_ff, lon_first_ff, clamp_min_ff, clamp_max_ff;
   logic [30:0]        lat_step_ff, lon_step_ff;
   logic [10:0]        rows_ff, cols_ff;

   // derived grid figures
   logic        grid_bad_ff, grid_bad_in;
   logic [10:0] rows_m1_ff, cols_m1_ff;
   logic [21:0] area;

   // pipeline
   item_type pipe_ff [NS];
   item_type stage_in [NS];
   logic     valid_ff [NS];
   logic     en [NS+1];

   // RAM ports
   logic                       ram_we, ram_re;
   logic [AW-1:0]              raddr [4];
   logic [mbgs_pkg::NODE_W-1:0] rdata [4];
   logic [mbgs_pkg::NODE_W-1:0] wdata;

   // response register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_value_ff, rsp_value_in;
   logic        rsp_ok_ff, rsp_ok_in;

   // clamp to configured bounds, lower bound first
   function automatic logic [31:0] clamp_value(input logic signed [36:0] x,
                                               input logic signed [31:0] lo,
                                               input logic signed [31:0] hi);
      logic signed [36:0] lo_x;
      logic signed [36:0] hi_x;
      lo_x = 37'(lo);
      hi_x = 37'(hi);
      if (x < lo_x) begin
         return lo;
      end else if (x > hi_x) begin
         return hi;
      end
      return x[31:0];
   endfunction

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         lat_first_ff <= '0;
         lon_first_ff <= '0;
         lat_step_ff  <= 31'd65536;
         lon_step_ff  <= 31'd65536;
         rows_ff      <= '0;
         cols_ff      <= '0;
         clamp_min_ff <= 32'sh8000_0000;
         clamp_max_ff <= 32'sh7FFF_FFFF;
      end else if (csr_we) begin
         case (mbgs_pkg::cfg_reg_type'(csr_index))
            mbgs_pkg::REG_LAT_FIRST: lat_first_ff <= csr_wdata;
            mbgs_pkg::REG_LON_FIRST: lon_first_ff <= csr_wdata;
            mbgs_pkg::REG_LAT_STEP:  lat_step_ff  <= csr_wdata[30:0];
            mbgs_pkg::REG_LON_STEP:  lon_step_ff  <= csr_wdata[30:0];
            mbgs_pkg::REG_ROWS:      rows_ff      <= csr_wdata[10:0];
            mbgs_pkg::REG_COLS:      cols_ff      <= csr_wdata[10:0];
            mbgs_pkg::REG_CLAMP_MIN: clamp_min_ff <= csr_wdata;
            mbgs_pkg::REG_CLAMP_MAX: clamp_max_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // grid size checks, refreshed every cycle
   always_comb begin
      area = 22'(rows_ff) * 22'(cols_ff);
      grid_bad_in = (rows_ff < 11'd2) || (cols_ff < 11'd2) || (area < 22'd4) ||
                    (32'(area) > 32'(GRID_ENTRIES));
   end

   always_ff @(posedge clock) begin
      grid_bad_ff <= grid_bad_in;
      rows_m1_ff  <= rows_ff - 11'd1;
      cols_m1_ff  <= cols_ff - 11'd1;
   end

   // stage logic
   always_comb begin
      item_type           it;
      logic [31:0]        ext_addr;
      logic [64:0]        prod_l, prod_n;
      logic signed [63:0] lat_lim, abs_n;
      logic [31:0]        i_full;
      logic [11:0]        t;
      logic               jfail;
      logic [10:0]        j_w;
      logic [22:0]        a_full;
      logic [31:0]        v00, v01, v10, v11;
      logic signed [32:0] dd0, dd1;
      logic signed [50:0] acc0, acc1;
      logic signed [35:0] dr;
      logic signed [53:0] acc2;

      // stage 0: unpack request, take offsets from the first node
      it = pipe_ff[0];
      it.kind     = req_tuser;
      ext_addr    = 32'(req_tdata[15:0]);
      it.wr_ok    = ext_addr < 32'(GRID_ENTRIES);
      it.wr_addr  = ext_addr[AW-1:0];
      it.wr_value = req_tdata[47:16];
      it.wr_dv    = req_tdata[48];
      it.wr_nv    = req_tdata[49];
      it.d_lat    = $signed({req_tdata[81], req_tdata[81:50]}) -
                    $signed({lat_first_ff[31], lat_first_ff});
      it.d_lon    = $signed({req_tdata[113], req_tdata[113:82]}) -
                    $signed({lon_first_ff[31], lon_first_ff});
      stage_in[0] = it;

      // stage 1: scale offsets into cell units
      it = pipe_ff[0];
      prod_l = 65'(it.d_lat) * 65'($signed({1'b0, lat_step_ff}));
      prod_n = 65'(it.d_lon) * 65'($signed({1'b0, lon_step_ff}));
      it.sl = prod_l[63:0];
      it.sn = prod_n[63:0];
      stage_in[1] = it;

      // stage 2: split into index and fraction, check the row range
      it = pipe_ff[1];
      lat_lim = $signed({21'b0, rows_m1_ff, 32'b0});
      i_full  = it.sl[63:32];
      it.fail = grid_bad_ff || it.sl[63] || (it.sl > lat_lim) ||
                ((WRAP_INDICES == 0) && (i_full >= 32'(rows_m1_ff)));
      if ((WRAP_INDICES != 0) && (i_full == 32'(rows_m1_ff))) begin
         it.i_w = '0;
      end else begin
         it.i_w = it.sl[42:32];
      end
      it.fx    = it.sl[31:16];
      it.j_neg = it.sn[63];
      abs_n    = it.sn[63] ? -it.sn : it.sn;
      it.j_abs = abs_n[62:32];
      if (it.sn[63]) begin
         it.fy = -$signed({1'b0, abs_n[31:16]});
      end else begin
         it.fy = $signed({1'b0, it.sn[31:16]});
      end
      it.rem    = '0;
      it.div_sh = {1'b0, abs_n[62:32]};
      stage_in[2] = it;

      // remainder stages: restoring steps of the column index
      for (int m = 0; m < mbgs_pkg::MOD_STAGES; m++) begin
         it = pipe_ff[S_MOD0 + m - 1];
         for (int s = 0; s < mbgs_pkg::MOD_STEPS; s++) begin
            t = {it.rem, it.div_sh[31]};
            it.div_sh = {it.div_sh[30:0], 1'b0};
            if (t >= {1'b0, cols_m1_ff}) begin
               t = t - {1'b0, cols_m1_ff};
            end
            it.rem = t[10:0];
         end
         stage_in[S_MOD0 + m] = it;
      end

      // address stage: final column index and corner base address
      it = pipe_ff[S_ADDR - 1];
      if (WRAP_INDICES != 0) begin
         jfail = it.j_neg && (it.rem != 11'd0);
         j_w   = it.j_neg ? 11'd0 : it.rem;
      end else begin
         jfail = it.j_neg ? (it.j_abs != 31'd0) :
                 (32'(it.j_abs) >= 32'(cols_m1_ff));
         j_w   = it.j_neg ? 11'd0 : it.j_abs[10:0];
      end
      it.fail = it.fail || jfail;
      a_full  = 23'(it.i_w) * 23'(cols_ff) + 23'(j_w);
      it.a00  = a_full[AW-1:0];
      stage_in[S_ADDR] = it;

      // memory stage: corner reads issued on entry
      stage_in[S_MEM] = pipe_ff[S_ADDR];

      // row stage: check masks and blend along columns
      it  = pipe_ff[S_MEM];
      v00 = rdata[0][31:0];
      v01 = rdata[1][31:0];
      v10 = rdata[2][31:0];
      v11 = rdata[3][31:0];
      it.corners_ok = rdata[0][32] && rdata[1][32] && rdata[2][32] && rdata[3][32] &&
                      rdata[0][33] && rdata[1][33] && rdata[2][33] && rdata[3][33];
      dd0  = $signed({v01[31], v01}) - $signed({v00[31], v00});
      dd1  = $signed({v11[31], v11}) - $signed({v10[31], v10});
      acc0 = $signed({{3{v00[31]}}, v00, 16'b0}) + dd0 * it.fy + 51'sd32768;
      acc1 = $signed({{3{v10[31]}}, v10, 16'b0}) + dd1 * it.fy + 51'sd32768;
      it.r0 = acc0[50:16];
      it.r1 = acc1[50:16];
      stage_in[S_ROW] = it;

      // column stage: blend across rows
      it   = pipe_ff[S_ROW];
      dr   = $signed({it.r1[34], it.r1}) - $signed({it.r0[34], it.r0});
      acc2 = $signed({{3{it.r0[34]}}, it.r0, 16'b0}) +
             dr * $signed({1'b0, it.fx}) + 54'sd32768;
      it.v = acc2[52:16];
      stage_in[S_COL] = it;
   end

   // stage enables: advance when empty or when the next stage advances
   always_comb begin
      en[NS] = !rsp_valid_ff || rsp_tready;
      for (int k = NS - 1; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
   end

   assign req_tready = en[0];

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NS; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else begin
         for (int k = 0; k < NS; k++) begin
            if (en[k]) begin
               valid_ff[k] <= (k == 0) ? req_tvalid : valid_ff[(k == 0) ? 0 : k - 1];
            end
         end
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      for (int k = 0; k < NS; k++) begin
         if (en[k]) begin
            pipe_ff[k] <= stage_in[k];
         end
      end
   end

   // corner stores: four copies, each read at one corner
   always_comb begin
      logic [22:0] base;
      base     = 23'(pipe_ff[S_ADDR].a00);
      raddr[0] = base[AW-1:0];
      raddr[1] = AW'(base + 23'd1);
      raddr[2] = AW'(base + 23'(cols_ff));
      raddr[3] = AW'(base + 23'(cols_ff) + 23'd1);
   end

   assign ram_we = en[S_MEM] && valid_ff[S_ADDR] &&
                   (pipe_ff[S_ADDR].kind == mbgs_pkg::KIND_WRITE) && pipe_ff[S_ADDR].wr_ok;
   assign ram_re = en[S_MEM] && valid_ff[S_ADDR] &&
                   (pipe_ff[S_ADDR].kind == mbgs_pkg::KIND_QUERY);
   assign wdata  = {pipe_ff[S_ADDR].wr_nv, pipe_ff[S_ADDR].wr_dv, pipe_ff[S_ADDR].wr_value};

   for (genvar c = 0; c < 4; c++) begin : g_corner
      mbgs_ram #(
         .WIDTH(mbgs_pkg::NODE_W),
         .DEPTH(GRID_ENTRIES)
      ) u_ram (
         .clock(clock),
         .we   (ram_we),
         .waddr(pipe_ff[S_ADDR].wr_addr),
         .wdata(wdata),
         .re   (ram_re),
         .raddr(raddr[c]),
         .rdata(rdata[c])
      );
   end

   // response: zero failed queries, clamp the rest and drop write items
   always_comb begin
      rsp_valid_in = valid_ff[NS-1] && (pipe_ff[NS-1].kind == mbgs_pkg::KIND_QUERY);
      if (pipe_ff[NS-1].fail) begin
         rsp_value_in = '0;
         rsp_ok_in    = 1'b0;
      end else if (!pipe_ff[NS-1].corners_ok) begin
         rsp_value_in = clamp_value(37'sd0, clamp_min_ff, clamp_max_ff);
         rsp_ok_in    = 1'b0;
      end else begin
         rsp_value_in = clamp_value(pipe_ff[NS-1].v, clamp_min_ff, clamp_max_ff);
         rsp_ok_in    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en[NS]) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en[NS]) begin
         rsp_value_ff <= rsp_value_in;
         rsp_ok_ff    <= rsp_ok_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_ok_ff;

`ifndef SYNTHESIS
   // a stage never takes a read and a write in one cycle
   assert property (@(posedge clock) disable iff (reset) !(ram_we && ram_re))
      else $error("corner store read and write in the same cycle");

   // a finished query reaches the response register
   assert property (@(posedge clock) disable iff (reset)
      valid_ff[NS-1] && en[NS] && (pipe_ff[NS-1].kind == mbgs_pkg::KIND_QUERY)
      |=> rsp_tvalid)
      else $error("query lost before the response register");

   // a good sample lies inside ordered clamp bounds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser && (clamp_min_ff <= clamp_max_ff)
      |-> ($signed(rsp_tdata) >= clamp_min_ff) && ($signed(rsp_tdata) <= clamp_max_ff))
      else $error("good sample outside the clamp bounds");

   // reset empties the response register
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");
`endif

endmodule
`default_nettype wire

FILE: hdl/mbgs_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbgs_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mbgs_ram #(
   parameter int WIDTH = mbgs_pkg::NODE_W,
   parameter int DEPTH = mbgs_pkg::GRID_ENTRIES_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write and registered read; hold read data while not enabled
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

FILE: verif/mbgs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbgs_checker
// Watches the request, response and register ports of the grid sampler.
// Keeps its own copy of the grid store and the registers, works out the
// sample for every accepted query and compares each response with the
// oldest outstanding sample, field by field.
// ----------------------------------------------------------------------------
module mbgs_checker #(
   parameter int GRID_ENTRIES = mbgs_pkg::GRID_ENTRIES_DEFAULT,
   parameter int WRAP_INDICES = mbgs_pkg::WRAP_INDICES_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   input  wire logic                              req_tready,
   input  wire logic [mbgs_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  wire logic                              req_tuser,
   input  wire logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   input  wire logic [mbgs_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  wire logic                              rsp_tuser,
   input  wire logic                              csr_we,
   input  wire logic [mbgs_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [mbgs_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output int                                     pending,
   output int                                     failures
);

   typedef struct packed {
      logic [31:0] value;
      logic        ok;
   } sample_type;

   sample_type     samples_due[$];

   // grid store: {net_valid, data_valid, value}
   logic [33:0]    node_store [GRID_ENTRIES];

   logic signed [31:0] lat_origin, lon_origin, floor_bound, ceil_bound;
   logic [30:0]        lat_scale, lon_scale;
   logic [10:0]        row_count, col_count;

   assign pending = samples_due.size();

   initial failures = 0;

   task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
      $display("mismatch at %0t: %s expected %h got %h", $realtime, what, want, got);
      failures++;
   endtask

   function automatic longint trunc_shr(input longint x, input int s);
      if (x >= 0)
         return x >>> s;
      return -((-x) >>> s);
   endfunction

   // weighted pair, rounded half up then floored
   function automatic longint mix(input longint a, input longint b, input longint f);
      return (a * (65536 - f) + b * f + 64'sd32768) >>> 16;
   endfunction

   function automatic sample_type sample_point(input logic signed [31:0] lat,
                                               input logic signed [31:0] lon);
      longint     rows, cols, sl, sn, i, j, fx, fy, v, r0, r1;
      int         a00;
      logic       all_valid;
      sample_type res;
      rows = longint'(row_count);
      cols = longint'(col_count);
      res  = '0;
      if (rows * cols < 4 || rows < 2 || cols < 2 || rows * cols > GRID_ENTRIES)
         return res;
      sl = (longint'(lat) - longint'(lat_origin)) * longint'(lat_scale);
      sn = (longint'(lon) - longint'(lon_origin)) * longint'(lon_scale);
      if (sl < 0 || sl > ((rows - 1) <<< 32))
         return res;
      i  = trunc_shr(sl, 32);
      j  = trunc_shr(sn, 32);
      fx = trunc_shr(sl - (i <<< 32), 16);
      fy = trunc_shr(sn - (j <<< 32), 16);
      // wrap reduces the indices; the fractions stay from the unreduced ones
      if (WRAP_INDICES != 0) begin
         i = i % (rows - 1);
         j = j % (cols - 1);
      end else if (i >= rows - 1 || j >= cols - 1) begin
         return res;
      end
      if (i < 0 || j < 0)
         return res;
      a00 = int'(i * cols + j);
      all_valid = &{node_store[a00][33:32], node_store[a00 + 1][33:32],
                    node_store[a00 + int'(cols)][33:32],
                    node_store[a00 + int'(cols) + 1][33:32]};
      v = 0;
      if (all_valid) begin
         r0 = mix(longint'($signed(node_store[a00][31:0])),
                  longint'($signed(node_store[a00 + 1][31:0])), fy);
         r1 = mix(longint'($signed(node_store[a00 + int'(cols)][31:0])),
                  longint'($signed(node_store[a00 + int'(cols) + 1][31:0])), fy);
         v  = mix(r0, r1, fx);
      end
      if (v < longint'(floor_bound))
         v = longint'(floor_bound);
      else if (v > longint'(ceil_bound))
         v = longint'(ceil_bound);
      res.value = v[31:0];
      res.ok    = all_valid;
      return res;
   endfunction

   always @(posedge clock) begin
      sample_type want;
      if (reset) begin
         lat_origin  <= '0;
         lon_origin  <= '0;
         lat_scale   <= 31'd65536;
         lon_scale   <= 31'd65536;
         row_count   <= '0;
         col_count   <= '0;
         floor_bound <= 32'sh8000_0000;
         ceil_bound  <= 32'sh7FFF_FFFF;
         samples_due.delete();
      end else begin
         // register writes
         if (csr_we) begin
            case (mbgs_pkg::cfg_reg_type'(csr_index))
               mbgs_pkg::REG_LAT_FIRST: lat_origin  <= csr_wdata;
               mbgs_pkg::REG_LON_FIRST: lon_origin  <= csr_wdata;
               mbgs_pkg::REG_LAT_STEP:  lat_scale   <= csr_wdata[30:0];
               mbgs_pkg::REG_LON_STEP:  lon_scale   <= csr_wdata[30:0];
               mbgs_pkg::REG_ROWS:      row_count   <= csr_wdata[10:0];
               mbgs_pkg::REG_COLS:      col_count   <= csr_wdata[10:0];
               mbgs_pkg::REG_CLAMP_MIN: floor_bound <= csr_wdata;
               mbgs_pkg::REG_CLAMP_MAX: ceil_bound  <= csr_wdata;
               default: ;
            endcase
         end
         // compare response with oldest sample
         if (rsp_tvalid && rsp_tready) begin
            if (samples_due.size() == 0) begin
               report("unexpected response", 32'h0, rsp_tdata);
            end else begin
               want = samples_due.pop_front();
               if (rsp_tdata !== want.value)
                  report("sampled_value", want.value, rsp_tdata);
               if (rsp_tuser !== want.ok)
                  report("sample_ok", {31'b0, want.ok}, {31'b0, rsp_tuser});
            end
         end
         // store node or predict sample
         if (req_tvalid && req_tready) begin
            if (req_tuser == mbgs_pkg::KIND_WRITE) begin
               if (int'(req_tdata[15:0]) < GRID_ENTRIES)
                  node_store[req_tdata[15:0]] <= req_tdata[49:16];
            end else begin
               samples_due.push_back(sample_point(req_tdata[81:50], req_tdata[113:82]));
            end
         end
      end
   end

endmodule

FILE: verif/tb_masked_bilinear_grid_sampler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_masked_bilinear_grid_sampler_top
// Drives the grid sampler through a sequence of register settings: loads a
// block of grid nodes, then sends directed and random node writes and
// queries under varying backpressure. A separate checker predicts and
// compares every response; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_masked_bilinear_grid_sampler_top;

   localparam int PHASES      = 10;
   localparam int PRELOAD     = 1024;
   localparam int PHASE_ITEMS = 85;
   localparam int IDLE_LIMIT  = 5000;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic [mbgs_pkg::REQ_DATA_W-1:0]     req_tdata = '0;
   logic                                req_tuser = mbgs_pkg::KIND_WRITE;
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic [mbgs_pkg::RSP_DATA_W-1:0]     rsp_tdata;
   logic                                rsp_tuser;
   logic                                csr_we = 1'b0;
   logic [mbgs_pkg::CSR_INDEX_W-1:0]    csr_index = '0;
   logic [mbgs_pkg::CSR_DATA_W-1:0]     csr_wdata = '0;

   int pending, failures;
   int send_idle_pct = 0, recv_stall_pct = 0;
   int quiet_cycles = 0;

   // live settings, mirrored for stimulus shaping
   logic [31:0] cfg [8];

   masked_bilinear_grid_sampler_top uut (.*);

   mbgs_checker chk (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   // response backpressure
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // stop when nothing moves for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > IDLE_LIMIT) begin
         $display("** masked_bilinear_grid_sampler_top: FAILED **");
         $finish;
      end
   end

   task automatic push_request(input logic kind, input logic [15:0] index,
                               input logic [31:0] value, input logic dv,
                               input logic nv, input logic [31:0] lat,
                               input logic [31:0] lon);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {6'b0, lon, lat, nv, dv, value, index};
      do
         @(posedge clock);
      while (!req_tready);
   endtask

   task automatic write_node(input logic [15:0] index, input logic [31:0] value,
                             input logic dv, input logic nv);
      push_request(mbgs_pkg::KIND_WRITE, index, value, dv, nv, $urandom, $urandom);
   endtask

   task automatic query(input logic [31:0] lat, input logic [31:0] lon);
      push_request(mbgs_pkg::KIND_QUERY, 16'($urandom), $urandom, 1'($urandom),
                   1'($urandom), lat, lon);
   endtask

   // hold the sender until every sample has come back, then let the pipe empty
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic apply_settings();
      for (int r = 0; r < 8; r++) begin
         csr_we    <= 1'b1;
         csr_index <= mbgs_pkg::cfg_reg_type'(r);
         csr_wdata <= cfg[r];
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   // query aimed at a chosen cell when one grid step is one degree
   task automatic aimed_query(input int i, input int j, input logic [15:0] fy,
                              input logic [15:0] fx);
      query(cfg[0] + (i <<< 16) + fx, cfg[1] + (j <<< 16) + fy);
   endtask

   task automatic random_item();
      int  rows, cols, i, j, span;
      bit  wide, aimed;
      rows  = int'(cfg[4]);
      cols  = int'(cfg[5]);
      wide  = rows * cols > PRELOAD;
      aimed = cfg[2] == 32'd65536 && cfg[3] == 32'd65536;
      if ($urandom_range(0, 3) == 0) begin
         // node rewrite, mostly valid and mostly inside the loaded block
         write_node(($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, PRELOAD - 1)),
                    $urandom, $urandom_range(0, 7) != 0, $urandom_range(0, 7) != 0);
      end else if (aimed) begin
         i = wide ? ($urandom_range(0, 1) ? 0 : -1) : $urandom_range(0, rows) - 1;
         j = $urandom_range(0, cols + 1) - 1;
         aimed_query(i, j, 16'($urandom), 16'($urandom));
      end else if ($urandom_range(0, 9) == 0) begin
         query($urandom, $urandom);
      end else begin
         span = $urandom_range(0, 1) ? 64 : 65536 * 8;
         query(cfg[0] + $urandom_range(0, 2 * span) - span,
               cfg[1] + $urandom_range(0, 2 * span) - span);
      end
   endtask

   initial begin
      logic [31:0] table_of_settings [PHASES][8];
      table_of_settings = '{
         '{32'd0, 32'd0, 32'd65536, 32'd65536, 32'd8, 32'd8, 32'h8000_0000, 32'h7FFF_FFFF},
         '{32'd0, 32'd0, 32'd65536, 32'd65536, 32'd1, 32'd5, 32'h8000_0000, 32'h7FFF_FFFF},
         '{32'd0, 32'd0, 32'd65536, 32'd65536, 32'd1024, 32'd1024, 32'h8000_0000, 32'h7FFF_FFFF},
         '{32'h0010_0000, 32'hFFF8_0000, 32'd65536, 32'd65536, 32'd64, 32'd512,
           32'h8000_0000, 32'h7FFF_FFFF},
         '{32'd0, 32'd0, 32'd65536, 32'd65536, 32'd16, 32'd16, 32'hFFFF_0000, 32'h0001_0000},
         '{32'h0003_0000, 32'd0, 32'd65536, 32'd65536, 32'd4, 32'd4, 32'd1000, -32'd1000},
         '{32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1, 32'd32, 32'd32,
           32'h8000_0000, 32'h7FFF_FFFF},
         '{32'd1000, -32'd1000, 32'd0, 32'h0001_2345, 32'd2, 32'd2, 32'h8000_0000, 32'd0},
         '{32'd0, 32'd0, 32'd65536, 32'd65536, 32'd0, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF},
         '{32'hFFF0_0000, 32'd12345, 32'd65536, 32'd65536, 32'd2, 32'd512,
           32'h8000_0000, 32'h7FFF_FFFF}};

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // load the first PRELOAD nodes of the grid store
      for (int n = 0; n < PRELOAD; n++)
         write_node(16'(n), $urandom, $urandom_range(0, 15) != 0, $urandom_range(0, 15) != 0);
      drain();

      for (int p = 0; p < PHASES; p++) begin
         cfg = table_of_settings[p];
         apply_settings();
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
            default: begin send_idle_pct = 19; recv_stall_pct = 19; end
         endcase

         // directed corners on the 8x8 setting
         if (p == 0) begin
            write_node(16'd0, 32'h7FFF_FFFF, 1'b1, 1'b1);
            write_node(16'd1, 32'h8000_0000, 1'b1, 1'b1);
            write_node(16'd8, 32'h7FFF_FFFF, 1'b1, 1'b1);
            write_node(16'd9, 32'h8000_0000, 1'b1, 1'b1);
            write_node(16'hFFFF, 32'h1234_5678, 1'b1, 1'b1);
            aimed_query(0, 0, 16'h0000, 16'h0000);
            aimed_query(0, 0, 16'hFFFF, 16'hFFFF);
            aimed_query(0, 0, 16'h8000, 16'h8000);
            aimed_query(0, -1, 16'hFFFF, 16'h4000);  // small negative lon offset
            aimed_query(7, 0, 16'h0000, 16'h0000);   // last row
            aimed_query(0, 7, 16'h0000, 16'h0000);   // last column
            aimed_query(-1, 0, 16'hFFFF, 16'h0000);  // latitude below grid
            aimed_query(3, -2, 16'h0000, 16'h0000);  // negative column index
            query(32'h8000_0000, 32'h7FFF_FFFF);
            query(32'h7FFF_FFFF, 32'h8000_0000);
            // invalid corners
            write_node(16'd9, 32'd5, 1'b0, 1'b1);
            aimed_query(1, 1, 16'h1000, 16'h1000);
            write_node(16'd9, 32'd5, 1'b1, 1'b0);
            aimed_query(0, 1, 16'h1000, 16'h1000);
            write_node(16'd9, 32'd5, 1'b1, 1'b1);
            aimed_query(0, 0, 16'h2000, 16'h3000);
            // hold off until the pipe is empty once mid phase
            drain();
         end

         for (int k = 0; k < PHASE_ITEMS; k++)
            random_item();
         drain();
      end

      if (failures == 0)
         $display("** masked_bilinear_grid_sampler_top: PASSED **");
      else
         $display("** masked_bilinear_grid_sampler_top: FAILED **");
      $finish;
   end

endmodule
